>>> sv/nli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nli_pkg: shared types and constants of the nodelist line indexer
// Transfer structs, action codes, keyword table and character codes.
// ----------------------------------------------------------------------------
package nli_pkg;

  // input item
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  text_byte;
    logic [15:0] default_zone;
  } in_item_t;

  // index record
  typedef struct packed {
    logic [15:0] zone_number;
    logic [15:0] net_number;
    logic [15:0] node_number;
    logic [15:0] point_number;
    logic [15:0] region_number;
    logic [15:0] hub_number;
    logic [31:0] line_offset;
    logic        is_terminator;
    logic        last_of_run;
  } out_item_t;

  // current address hierarchy
  typedef struct packed {
    logic [15:0] zone;
    logic [15:0] net;
    logic [15:0] node;
    logic [15:0] point;
    logic [15:0] region;
    logic [15:0] hub;
  } hier_t;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam int NUM_KW = 8;

  localparam logic [2:0] KW_ZONE   = 3'd0;
  localparam logic [2:0] KW_REGION = 3'd1;
  localparam logic [2:0] KW_HOST   = 3'd2;
  localparam logic [2:0] KW_HUB    = 3'd3;
  localparam logic [2:0] KW_PVT    = 3'd4;
  localparam logic [2:0] KW_HOLD   = 3'd5;
  localparam logic [2:0] KW_COMMA  = 3'd6;
  localparam logic [2:0] KW_POINT  = 3'd7;

  // lower-case keyword text, character c at bits [8*c +: 8]
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_002c_656e_6f7a,  // zone,
    64'h002c_6e6f_6967_6572,  // region,
    64'h0000_002c_7473_6f68,  // host,
    64'h0000_0000_2c62_7568,  // hub,
    64'h0000_0000_2c74_7670,  // pvt,
    64'h0000_002c_646c_6f68,  // hold,
    64'h0000_0000_0000_002c,  // ,
    64'h0000_2c74_6e69_6f70   // point,
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd7, 4'd5, 4'd4, 4'd4, 4'd5, 4'd1, 4'd6
  };

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;

  localparam int         FIFO_DEPTH = 4;
  localparam logic [2:0] FIFO_ADMIT = 3'(FIFO_DEPTH - 2);

endpackage
`default_nettype wire

>>> sv/nli_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nli_parser: line state and hierarchy tracking
// Consumes one item per cycle while go is high and produces up to two index records.
// ----------------------------------------------------------------------------
module nli_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire nli_pkg::in_item_t  item,
  output nli_pkg::out_item_t      rec0,
  output nli_pkg::out_item_t      rec1,
  output logic [1:0]              rec_count
);
  import nli_pkg::*;

  hier_t       hier, hier_next, fin_hier;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] line_start, line_start_next;
  logic [3:0]  column, column_next;
  logic [7:0]  keyword_mask, keyword_mask_next, mask_upd;
  logic [15:0] number_acc, number_acc_next;
  logic [1:0]  number_phase, number_phase_next;
  logic        number_negative, number_negative_next;

  logic        match_valid;
  logic [2:0]  match_idx;
  logic [15:0] num_val;
  logic [7:0]  b, lb;
  logic        b_space, b_digit;
  logic [15:0] acc_x10;

  // priority match: lowest keyword index wins
  always_comb begin
    match_valid = 1'b0;
    match_idx   = KW_ZONE;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (keyword_mask[k] && (KW_LEN[k] <= column)) begin
        match_valid = 1'b1;
        match_idx   = 3'(k);
      end
    end
  end

  assign b       = item.text_byte;
  assign lb      = ((b >= CH_UPA) && (b <= CH_UPZ)) ? (b + 8'd32) : b;
  assign b_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign b_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_x10 = {number_acc[12:0], 3'b000} + {number_acc[14:0], 1'b0};
  assign num_val = number_negative ? (~number_acc + 16'd1) : number_acc;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      mask_upd[k] = keyword_mask[k];
      if (keyword_mask[k] && (column < KW_LEN[k]) &&
          (KW_TEXT[k][{column[2:0], 3'b000} +: 8] != lb))
        mask_upd[k] = 1'b0;
    end
  end

  // hierarchy after the current line is finished
  always_comb begin
    fin_hier = hier;
    if (match_valid) begin
      case (match_idx)
        KW_ZONE: begin
          fin_hier.zone = num_val;  fin_hier.net = num_val;
          fin_hier.region = '0; fin_hier.hub = '0;
          fin_hier.node = '0;   fin_hier.point = '0;
        end
        KW_REGION: begin
          fin_hier.region = num_val; fin_hier.net = num_val;
          fin_hier.hub = '0; fin_hier.node = '0; fin_hier.point = '0;
        end
        KW_HOST: begin
          fin_hier.net = num_val;
          fin_hier.hub = '0; fin_hier.node = '0; fin_hier.point = '0;
        end
        KW_HUB: begin
          fin_hier.hub = num_val; fin_hier.node = num_val; fin_hier.point = '0;
        end
        KW_PVT, KW_HOLD, KW_COMMA: begin
          fin_hier.node = num_val; fin_hier.point = '0;
        end
        KW_POINT: fin_hier.point = num_val;
        default: fin_hier = hier;
      endcase
    end
  end

  function automatic out_item_t make_entry(hier_t h, logic [31:0] ofs, logic last);
    out_item_t r;
    r.zone_number   = h.zone;
    r.net_number    = h.net;
    r.node_number   = h.node;
    r.point_number  = h.point;
    r.region_number = h.region;
    r.hub_number    = h.hub;
    r.line_offset   = ofs;
    r.is_terminator = 1'b0;
    r.last_of_run   = last;
    return r;
  endfunction

  function automatic out_item_t make_term();
    out_item_t r;
    r               = '0;
    r.line_offset   = '1;
    r.is_terminator = 1'b1;
    r.last_of_run   = 1'b1;
    return r;
  endfunction

  always_comb begin
    hier_next            = hier;
    byte_position_next   = byte_position;
    line_start_next      = line_start;
    column_next          = column;
    keyword_mask_next    = keyword_mask;
    number_acc_next      = number_acc;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    rec0                 = '0;
    rec1                 = '0;
    rec_count            = 2'd0;

    if (go) begin
      case (item.action)
        ACT_START: begin
          hier_next          = '0;
          hier_next.zone     = item.default_zone;
          byte_position_next = '0;
          line_start_next    = '0;
          column_next        = '0;
          keyword_mask_next  = '1;
          number_acc_next    = '0;
          number_phase_next  = PH_SKIP;
          number_negative_next = 1'b0;
        end
        ACT_BYTE: begin
          byte_position_next = byte_position + 32'd1;
          if (b == CH_LF) begin
            hier_next         = fin_hier;
            line_start_next   = byte_position + 32'd1;
            column_next       = '0;
            keyword_mask_next = '1;
            number_acc_next   = '0;
            number_phase_next = PH_SKIP;
            number_negative_next = 1'b0;
            if (match_valid) begin
              rec0      = make_entry(fin_hier, line_start, 1'b1);
              rec_count = 2'd1;
            end
          end else begin
            if (match_valid) begin
              // atoi-style number after the prefix
              if (number_phase == PH_SKIP) begin
                if (b_space) begin
                  number_phase_next = PH_SKIP;
                end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                  number_negative_next = (b == CH_MINUS);
                  number_phase_next    = PH_DIGITS;
                end else if (b_digit) begin
                  number_acc_next   = acc_x10 + {8'd0, b - CH_ZERO};
                  number_phase_next = PH_DIGITS;
                end else begin
                  number_phase_next = PH_DONE;
                end
              end else if (number_phase == PH_DIGITS) begin
                if (b_digit)
                  number_acc_next = acc_x10 + {8'd0, b - CH_ZERO};
                else
                  number_phase_next = PH_DONE;
              end
            end else begin
              keyword_mask_next = mask_upd;
            end
            if (column != 4'd15)
              column_next = column + 4'd1;
          end
        end
        ACT_END: begin
          hier_next         = '0;
          line_start_next   = byte_position;
          column_next       = '0;
          keyword_mask_next = '1;
          number_acc_next   = '0;
          number_phase_next = PH_SKIP;
          number_negative_next = 1'b0;
          if ((column != 4'd0) && match_valid) begin
            rec0      = make_entry(fin_hier, line_start, 1'b0);
            rec1      = make_term();
            rec_count = 2'd2;
          end else begin
            rec0      = make_term();
            rec_count = 2'd1;
          end
        end
        default: begin
          rec_count = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hier            <= '0;
      byte_position   <= '0;
      line_start      <= '0;
      column          <= '0;
      keyword_mask    <= '1;
      number_acc      <= '0;
      number_phase    <= PH_SKIP;
      number_negative <= 1'b0;
    end else begin
      hier            <= hier_next;
      byte_position   <= byte_position_next;
      line_start      <= line_start_next;
      column          <= column_next;
      keyword_mask    <= keyword_mask_next;
      number_acc      <= number_acc_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/nli_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nli_out_fifo: record queue with a two-wide write side
// Takes zero, one or two records per cycle and delivers one per transfer.
// ----------------------------------------------------------------------------
module nli_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push_count,
  input  wire nli_pkg::out_item_t  push0,
  input  wire nli_pkg::out_item_t  push1,
  output logic                     room,
  output logic                     rec_valid,
  input  wire logic                rec_ready,
  output nli_pkg::out_item_t       rec
);
  import nli_pkg::*;

  out_item_t  entries [FIFO_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = rec_valid && rec_ready;
  assign rec_valid = (count != 3'd0);
  assign rec       = entries[rd_ptr];
  // room for a full pair, judged on the registered count
  assign room      = (count <= FIFO_ADMIT);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0)
      entries[wr_ptr] <= push0;
    if (push_count == 2'd2)
      entries[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop)
        rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

>>> sv/nodelist_line_indexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nodelist_line_indexer: streaming nodelist parser that emits index records
//
// Input channel (item_valid/item_ready/item): one transfer per action,
// start of list, a text byte, or end of list. Output channel
// (rec_valid/rec_ready/rec): index records, one per transfer.
// A byte transfer yields one record on a newline that ends a known line,
// else none; an end transfer yields an optional flushed record and then
// the terminator; a start transfer yields nothing.
// A record is offered on rec once its input item has been held in item_q
// and then written into the record queue; a second record from an end item
// follows once the first has gone.
// Throughput: one input transfer per cycle while the 4-entry record queue
// has room for a pair. With the receiver taking every cycle, byte items
// never stall; a run of back-to-back end items (two records each) outpaces
// the one-record-per-cycle output and holds item_ready low until it drains.
// Reset clears the line state and hierarchy, empties the queue and drops
// a held item. When the receiver stalls, records collect in the queue and
// item_ready falls once an item is held and the queue cannot take a pair.
// ----------------------------------------------------------------------------
module nodelist_line_indexer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire nli_pkg::in_item_t   item,
  output logic                     rec_valid,
  input  wire logic                rec_ready,
  output nli_pkg::out_item_t       rec
);
  import nli_pkg::*;

  in_item_t   item_q;
  logic       full_q, full_q_next;
  logic       room;
  logic       advance;
  out_item_t  rec0, rec1;
  logic [1:0] rec_count;

  // held item is processed once the queue can take both possible records
  assign advance     = full_q && room;
  assign item_ready  = !full_q || advance;
  assign full_q_next = (item_valid && item_ready) || (full_q && !advance);

  always_ff @(posedge clk) begin
    if (item_valid && item_ready)
      item_q <= item;
  end

  always_ff @(posedge clk) begin
    if (rst)
      full_q <= 1'b0;
    else
      full_q <= full_q_next;
  end

  nli_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (item_q),
    .rec0      (rec0),
    .rec1      (rec1),
    .rec_count (rec_count)
  );

  nli_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (rec_count),
    .push0      (rec0),
    .push1      (rec1),
    .room       (room),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  // input stalls only while an item is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> full_q)
    else $error("item_ready low with no held item");

  // an end item always leaves a record waiting
  a_end_gives_rec: assert property (@(posedge clk) disable iff (rst)
    (advance && (item_q.action == ACT_END)) |=> rec_valid)
    else $error("end item produced no record");

  // terminator carries zero address and all-ones offset
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec.is_terminator) |->
      ((rec.line_offset == 32'hFFFF_FFFF) && (rec.zone_number == 16'd0) &&
       (rec.net_number == 16'd0) && rec.last_of_run))
    else $error("malformed terminator record");

endmodule
`default_nettype wire

>>> test/nodelist_index_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nodelist_index_checker: record predictor and comparator
// Watches both channels of the line indexer, keeps its own copy of the
// parse state, queues the records each input transfer should produce and
// compares every record transfer against the oldest queued one.
// ----------------------------------------------------------------------------
module nodelist_index_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire logic               item_ready,
  input  wire nli_pkg::in_item_t  item,
  input  wire logic               rec_valid,
  input  wire logic               rec_ready,
  input  wire nli_pkg::out_item_t rec,
  output int                      fail_count,
  output int                      records_pending
);
  import nli_pkg::*;

  hier_t       addr;
  logic [31:0] byte_count;
  logic [31:0] line_origin;
  logic [3:0]  line_col;
  logic [7:0]  live_words;
  logic [15:0] digits_value;
  logic [1:0]  digits_phase;
  logic        digits_negative;
  out_item_t   expected_records [$];
  int          mismatch_total = 0;

  assign fail_count = mismatch_total;

  // printing is capped so a broken build cannot flood the log
  task automatic report_mismatch(input string msg);
    if (mismatch_total < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic string word_text(input int k);
    case (k)
      KW_ZONE:   return "zone,";
      KW_REGION: return "region,";
      KW_HOST:   return "host,";
      KW_HUB:    return "hub,";
      KW_PVT:    return "pvt,";
      KW_HOLD:   return "hold,";
      KW_COMMA:  return ",";
      default:   return "point,";
    endcase
  endfunction

  // lowest live keyword whose text has been fully seen, -1 if none
  function automatic int complete_word();
    string s;
    for (int k = 0; k < NUM_KW; k++) begin
      s = word_text(k);
      if (live_words[k] && s.len() <= line_col) return k;
    end
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic out_item_t make_record(input bit term);
    out_item_t r;
    r = '0;
    r.zone_number   = addr.zone;
    r.net_number    = addr.net;
    r.node_number   = addr.node;
    r.point_number  = addr.point;
    r.region_number = addr.region;
    r.hub_number    = addr.hub;
    r.line_offset   = term ? 32'hFFFF_FFFF : line_origin;
    r.is_terminator = term;
    return r;
  endfunction

  task automatic reset_line();
    line_col        = '0;
    live_words      = 8'hFF;
    digits_value    = '0;
    digits_phase    = PH_SKIP;
    digits_negative = 1'b0;
  endtask

  // atoi-style digit accumulation, modulo 2^16
  task automatic take_digit(input logic [7:0] b);
    if (digits_phase == PH_SKIP) begin
      if (is_blank(b)) return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        digits_negative = (b == CH_MINUS);
        digits_phase    = PH_DIGITS;
        return;
      end
      digits_phase = PH_DIGITS;
    end
    if (digits_phase == PH_DIGITS) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        digits_value = digits_value * 16'd10 + {8'd0, b - CH_ZERO};
      end else begin
        digits_phase = PH_DONE;
      end
    end
  endtask

  // applies the hierarchy rules for the matched keyword
  task automatic close_line(output bit made, output out_item_t r);
    int          k;
    logic [15:0] n;
    k    = complete_word();
    n    = digits_negative ? 16'd0 - digits_value : digits_value;
    made = 1'b1;
    case (k)
      KW_ZONE: begin
        addr.zone = n;   addr.net = n;  addr.region = '0;
        addr.hub  = '0;  addr.node = '0; addr.point = '0;
      end
      KW_REGION: begin
        addr.region = n; addr.net = n;
        addr.hub = '0;   addr.node = '0; addr.point = '0;
      end
      KW_HOST: begin
        addr.net = n; addr.hub = '0; addr.node = '0; addr.point = '0;
      end
      KW_HUB: begin
        addr.hub = n; addr.node = n; addr.point = '0;
      end
      KW_PVT, KW_HOLD, KW_COMMA: begin
        addr.node = n; addr.point = '0;
      end
      KW_POINT: addr.point = n;
      default:  made = 1'b0;
    endcase
    r = make_record(1'b0);
    reset_line();
  endtask

  task automatic predict_transfer(input in_item_t it);
    out_item_t  r;
    bit         made;
    logic [7:0] lb;
    string      s;
    case (it.action)
      ACT_START: begin
        addr        = '0;
        addr.zone   = it.default_zone;
        byte_count  = '0;
        line_origin = '0;
        reset_line();
      end
      ACT_BYTE: begin
        byte_count = byte_count + 32'd1;
        if (it.text_byte == CH_LF) begin
          close_line(made, r);
          line_origin = byte_count;
          if (made) begin
            r.last_of_run = 1'b1;
            expected_records.push_back(r);
          end
        end else begin
          if (complete_word() >= 0) begin
            take_digit(it.text_byte);
          end else begin
            lb = it.text_byte;
            if (lb >= CH_UPA && lb <= CH_UPZ) lb = lb + 8'h20;
            for (int k = 0; k < NUM_KW; k++) begin
              s = word_text(k);
              if (live_words[k] && line_col < s.len() && s[line_col] != lb) begin
                live_words[k] = 1'b0;
              end
            end
          end
          if (line_col != 4'd15) line_col = line_col + 4'd1;
        end
      end
      ACT_END: begin
        if (line_col != 0) begin
          close_line(made, r);
          if (made) expected_records.push_back(r);
        end else begin
          reset_line();
        end
        line_origin = byte_count;
        addr        = '0;
        r = make_record(1'b1);
        r.last_of_run = 1'b1;
        expected_records.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      addr        = '0;
      byte_count  = '0;
      line_origin = '0;
      reset_line();
      expected_records.delete();
    end else begin
      if (item_valid && item_ready) predict_transfer(item);
      if (rec_valid && rec_ready) begin
        if (expected_records.size() == 0) begin
          report_mismatch("record transfer with nothing expected");
        end else begin
          want = expected_records.pop_front();
          check_field("zone_number",   rec.zone_number,   want.zone_number);
          check_field("net_number",    rec.net_number,    want.net_number);
          check_field("node_number",   rec.node_number,   want.node_number);
          check_field("point_number",  rec.point_number,  want.point_number);
          check_field("region_number", rec.region_number, want.region_number);
          check_field("hub_number",    rec.hub_number,    want.hub_number);
          check_field("line_offset",   rec.line_offset,   want.line_offset);
          check_field("is_terminator", rec.is_terminator, want.is_terminator);
          check_field("last_of_run",   rec.last_of_run,   want.last_of_run);
        end
      end
    end
    records_pending <= expected_records.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the nodelist line indexer
// Streams directed and random nodelist text (keyword lines with random case,
// whitespace, signs and overflowing numbers, plus noise, starts, ends and
// ignored actions) through the block under several idle/stall mixes. The
// checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module tb_top;
  import nli_pkg::*;

  // action code 3 has no meaning; the block must drop it silently
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int         QUIET_LIMIT = 2000;  // cycles without any transfer
  localparam int         PHASE_ITEMS = 120;

  logic      clk;
  logic      rst         = 1'b1;
  logic      item_valid  = 1'b0;
  logic      item_ready;
  in_item_t  item        = '0;
  logic      rec_valid;
  logic      rec_ready   = 1'b0;
  out_item_t rec;

  int        fail_count;
  int        records_pending;

  // idling knobs, percent per cycle
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // a flip of hold_toggle asks the receiver for one long hold-off
  logic      hold_toggle = 1'b0;
  logic      hold_seen   = 1'b0;
  int        hold_left   = 0;

  int        items_sent  = 0;
  int        quiet_cycles = 0;

  nodelist_line_indexer u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec)
  );

  nodelist_index_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .rec_valid       (rec_valid),
    .rec_ready       (rec_ready),
    .rec             (rec),
    .fail_count      (fail_count),
    .records_pending (records_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, or a counted hold-off when the stimulus asks
  // for one. Ready is free to move, so outside a hold-off it is redrawn every cycle.
  always @(posedge clk) begin
    if (rst) begin
      rec_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      rec_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rec_ready <= 1'b0;
    end else begin
      rec_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (rec_valid && rec_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer. A random gap (valid low) may come first; then
  // valid is held with a fixed payload until the transfer happens. The
  // ready seen right after the edge is the one the edge used.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                           input logic [15:0] z);
    in_item_t v;
    v.action       = act;
    v.text_byte    = b;
    v.default_zone = z;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // unused fields carry random values so every input bit toggles
  task automatic send_byte(input logic [7:0] b);
    send_item(ACT_BYTE, b, 16'($urandom));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender stops offering and waits for every outstanding record
  task automatic drain_records();
    item_valid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
  endtask

  // One nodelist line. Mostly well-formed keyword lines with random case,
  // blanks, sign and 0..7 digits (7 digits overflow 16 bits); some with a
  // corrupted prefix byte, some pure noise. A few are left unterminated.
  task automatic send_random_line();
    int         kind;
    int         k;
    int         bad_at;
    int         sign_pick;
    logic [7:0] c;
    kind   = $urandom_range(0, 11);
    k      = $urandom_range(0, NUM_KW - 1);
    bad_at = (kind == 10) ? $urandom_range(0, KW_LEN[k] - 1) : -1;
    if (kind == 11) begin
      repeat ($urandom_range(0, 18)) send_byte(8'($urandom));
    end else begin
      for (int i = 0; i < KW_LEN[k]; i++) begin
        c = KW_TEXT[k][8*i +: 8];
        if (i == bad_at) c = 8'($urandom);
        else if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1)) c = c - 8'h20;
        send_byte(c);
      end
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(3) == 0) send_byte(CH_SPACE);
        else send_byte(8'($urandom_range(CH_TAB, CH_CR)));
      end
      sign_pick = $urandom_range(3);
      if (sign_pick == 0) send_byte(CH_PLUS);
      else if (sign_pick == 1) send_byte(CH_MINUS);
      repeat ($urandom_range(0, 7)) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
    if ($urandom_range(19) != 0) send_byte(CH_LF);
  endtask

  // occasional list boundaries and ignored actions between lines
  task automatic send_random_event();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) send_item(ACT_START, 8'($urandom), 16'($urandom));
    else if (pick < 8) send_item(ACT_END, 8'($urandom), 16'($urandom));
    else if (pick < 11) send_item(ACT_UNUSED, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      send_random_event();
      send_random_line();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: text before any start, start at the top zone value, an
    // ignored action, mixed case with a negative number, an end right after
    // a newline (terminator only), start at zone zero, and an unterminated line
    // with a tab before its number, flushed by the end.
    send_text(",5\n");
    send_item(ACT_START, 8'h00, 16'hFFFF);
    send_item(ACT_UNUSED, 8'hFF, 16'hFFFF);
    send_text("pOiNt,-1\n");
    send_item(ACT_END, 8'hFF, 16'h0000);
    send_item(ACT_START, 8'hFF, 16'h0000);
    send_text("HUB,\t9");
    send_item(ACT_END, 8'h00, 16'hFFFF);

    // No idling. Midway the receiver holds off for a long stretch while
    // lines keep coming, so the record queue fills and input stalls.
    send_item(ACT_START, 8'($urandom), 16'($urandom));
    run_random(PHASE_ITEMS / 2);
    hold_toggle <= ~hold_toggle;
    run_random(60);
    drain_records();
    run_random(PHASE_ITEMS / 2);

    send_idle_pct  = 55;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 55;
    run_random(PHASE_ITEMS);

    send_idle_pct  = 33;
    recv_stall_pct = 33;
    run_random(PHASE_ITEMS);
    send_item(ACT_END, 8'($urandom), 16'($urandom));

    // wind down: receiver always ready, wait out the last records
    recv_stall_pct = 0;
    drain_records();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && records_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
